/* rtl/pps_pkg.sv */
// Shared types, constants and helpers for the preemptive priority scheduler.
`timescale 1ns / 1ps

package pps_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int SLOT_W        = $clog2(MAX_PROCESSES);
	localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
	localparam int TIME_W        = 21;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] process_id;
		logic [15:0] arrival_time;
		logic [15:0] burst_length;
		logic [7:0]  priority_level;
	} item_t;

	typedef struct packed {
		logic [15:0]       running_id;
		logic              idle;
		logic [TIME_W-1:0] tick_time;
		logic              first_dispatch;
		logic              completed;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] response;
		logic              all_done;
		logic [TIME_W-1:0] busy_ticks;
		logic              table_full;
	} result_t;

	typedef struct packed {
		logic [15:0]       id;
		logic [15:0]       arrival;
		logic [15:0]       burst;
		logic [15:0]       remaining;
		logic [7:0]        prio;
		logic [TIME_W-1:0] start;
		logic              started;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		entry_t            data;
	} tbl_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_EMIT
	} state_t;

	function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
		return (v == TIME_MAX) ? v : v + 1'b1;
	endfunction

endpackage

/* rtl/pps_table.sv */
// Process table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module pps_table
	import pps_pkg::*;
(
	input  logic              clk,
	input  tbl_wr_t           wr,
	input  logic [SLOT_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [MAX_PROCESSES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/pps_cmp.sv */
// Shared selection comparator: does the candidate beat the current best.
`timescale 1ns / 1ps

module pps_cmp
	import pps_pkg::*;
(
	input  entry_t            cand,
	input  logic [TIME_W-1:0] now,
	input  logic              best_valid,
	input  logic [7:0]        best_prio,
	input  logic [15:0]       best_arrival,
	output logic              take
);

	logic eligible;
	logic better;

	always_comb begin
		eligible = (cand.remaining != '0) && ({5'b0, cand.arrival} <= now);
		// strict compares keep the lower slot on a full tie
		better   = (cand.prio < best_prio) ||
		           ((cand.prio == best_prio) && (cand.arrival < best_arrival));
		take     = eligible && (!best_valid || better);
	end

endmodule

/* rtl/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler: sequencer, counters, result register.
//
// Usage:
//   Items arrive on the item channel (item_valid / item_ready / item). Each item
//   is a transaction of kind clear, load or tick; every item yields exactly one
//   transaction on the result channel (result_valid / result_ready / result).
//   A clear or load is handled in the accept cycle; its result then passes
//   through the emit state into the result register. A tick scans the loaded
//   slots one per cycle through a single shared comparator, one registered
//   read of the process table per slot, then picks the best entry and emits
//   its result into the result register. item_ready is high only while the
//   sequencer waits for an item.
//   The result register holds one finished transaction; a new item is taken
//   while it still waits, and a stalled receiver stops the sequencer only when
//   the next result is due.
//   Reset (arst_n low) empties the table, zeroes time and counters and drops
//   any pending result; a clear item does the same to the scheduling state.
`timescale 1ns / 1ps

module preemptive_priority_scheduler
	import pps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  loaded_q;
	logic [CNT_W-1:0]  finished_q;
	logic [TIME_W-1:0] time_q;
	logic [15:0]       earliest_q;
	logic              clk_started_q;
	logic [TIME_W-1:0] busy_q;

	// scan control
	logic [CNT_W-1:0]  issue_q;
	logic              pend_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              best_valid_q;
	logic [SLOT_W-1:0] best_slot_q;
	entry_t            best_q;

	result_t res_q;
	result_t result_q;
	logic    result_valid_q;

	tbl_wr_t           tbl_wr;
	logic [SLOT_W-1:0] tbl_raddr;
	entry_t            tbl_rdata;
	logic              take;
	logic              issue;
	logic              emit_go;
	logic              full;

	// pick stage arithmetic
	logic [15:0]       pick_rem;
	logic [TIME_W-1:0] next_time;
	logic [TIME_W-1:0] pick_ta;
	logic [TIME_W-1:0] pick_wait;
	logic [TIME_W-1:0] pick_start;
	logic [TIME_W-1:0] pick_resp;

	// report seeds: at accept and at emit
	result_t accept_res;
	result_t emit_res;

	pps_table u_table (
		.clk   (clk),
		.wr    (tbl_wr),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	pps_cmp u_cmp (
		.cand         (tbl_rdata),
		.now          (time_q),
		.best_valid   (best_valid_q),
		.best_prio    (best_q.prio),
		.best_arrival (best_q.arrival),
		.take         (take)
	);

	assign full    = (loaded_q >= CNT_W'(MAX_PROCESSES));
	assign emit_go = !result_valid_q || result_ready;

	always_comb begin
		pick_rem   = best_q.remaining - 1'b1;
		next_time  = sat_inc(time_q);
		pick_ta    = next_time - {5'b0, best_q.arrival};
		pick_wait  = (pick_ta >= {5'b0, best_q.burst}) ? (pick_ta - {5'b0, best_q.burst}) : '0;
		pick_start = best_q.started ? best_q.start : time_q;
		pick_resp  = pick_start - {5'b0, best_q.arrival};

		// refused load and tick on an empty table are settled at accept
		accept_res            = '0;
		accept_res.table_full = (item.kind == KIND_LOAD) && full;
		accept_res.idle       = (item.kind == KIND_TICK) && (loaded_q == '0);

		emit_res            = res_q;
		emit_res.all_done   = (finished_q == loaded_q);
		emit_res.busy_ticks = busy_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = (item.kind == KIND_TICK && loaded_q != '0) ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (!issue && !pend_s1) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_ready    = 1'b0;
		issue         = 1'b0;
		tbl_raddr     = issue_q[SLOT_W-1:0];
		tbl_wr        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && item.kind == KIND_LOAD && !full) begin
					tbl_wr.en             = 1'b1;
					tbl_wr.addr           = loaded_q[SLOT_W-1:0];
					tbl_wr.data.id        = item.process_id;
					tbl_wr.data.arrival   = item.arrival_time;
					tbl_wr.data.burst     = item.burst_length;
					tbl_wr.data.remaining = item.burst_length;
					tbl_wr.data.prio      = item.priority_level;
					tbl_wr.data.start     = '0;
					tbl_wr.data.started   = 1'b0;
				end
			end
			ST_SCAN: begin
				issue = (issue_q < loaded_q);
			end
			ST_PICK: begin
				if (best_valid_q) begin
					tbl_wr.en             = 1'b1;
					tbl_wr.addr           = best_slot_q;
					tbl_wr.data           = best_q;
					tbl_wr.data.remaining = pick_rem;
					tbl_wr.data.start     = pick_start;
					tbl_wr.data.started   = 1'b1;
				end
			end
			ST_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			loaded_q       <= '0;
			finished_q     <= '0;
			time_q         <= '0;
			earliest_q     <= '1;
			clk_started_q  <= 1'b0;
			busy_q         <= '0;
			issue_q        <= '0;
			pend_s1        <= 1'b0;
			slot_s1        <= '0;
			best_valid_q   <= 1'b0;
			best_slot_q    <= '0;
			best_q         <= '0;
			res_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && emit_go) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						res_q <= accept_res;
						case (item.kind)
							KIND_CLEAR: begin
								loaded_q      <= '0;
								finished_q    <= '0;
								time_q        <= '0;
								earliest_q    <= '1;
								clk_started_q <= 1'b0;
								busy_q        <= '0;
							end
							KIND_LOAD: begin
								if (!full) begin
									loaded_q <= loaded_q + 1'b1;
									// zero burst counts as done at load
									if (item.burst_length == '0) begin
										finished_q <= finished_q + 1'b1;
									end
									if (item.arrival_time < earliest_q) begin
										earliest_q <= item.arrival_time;
									end
								end
							end
							KIND_TICK: begin
								if (loaded_q != '0) begin
									// first tick: time jumps to earliest arrival
									if (!clk_started_q) begin
										time_q        <= {5'b0, earliest_q};
										clk_started_q <= 1'b1;
									end
									issue_q      <= '0;
									pend_s1      <= 1'b0;
									best_valid_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					pend_s1 <= issue;
					slot_s1 <= issue_q[SLOT_W-1:0];
					if (issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (pend_s1 && take) begin
						best_valid_q <= 1'b1;
						best_slot_q  <= slot_s1;
						best_q       <= tbl_rdata;
					end
				end
				ST_PICK: begin
					res_q.tick_time <= time_q;
					time_q          <= next_time;
					if (!best_valid_q) begin
						res_q.idle <= 1'b1;
					end else begin
						res_q.running_id     <= best_q.id;
						res_q.first_dispatch <= !best_q.started;
						busy_q               <= sat_inc(busy_q);
						if (pick_rem == '0) begin
							finished_q            <= finished_q + 1'b1;
							res_q.completed       <= 1'b1;
							res_q.completion_time <= next_time;
							res_q.turnaround      <= pick_ta;
							res_q.waiting         <= pick_wait;
							res_q.response        <= pick_resp;
						end
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						result_q <= emit_res;
					end
				end
				default: ;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// finished processes never outnumber loaded ones
	a_finished_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q <= loaded_q)
		else $error("finished count exceeds loaded count");

	// the block goes busy after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous one in progress");

	// an idle tick reports no process and no completion
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.idle |-> result.running_id == '0 && !result.completed)
		else $error("idle result carries a process");

	// a completion always comes from a pick on a valid best entry
	a_complete_from_pick: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PICK && !best_valid_q |=> !res_q.completed && res_q.idle)
		else $error("completion without a selected process");
`endif

endmodule
